// File: src/bgf_pkg.sv
// shared constants, widths and types for the bilinear gradient fill unit
// no dependencies; imported by every module of the block

package bgf_pkg;

   // largest rectangle side; larger programmed sides are clipped to this
   localparam int unsigned MAX_SIDE = 4096;

   // field widths
   localparam int POS_W      = 12;
   localparam int SIDE_W     = 13;
   localparam int CHAN_W     = 8;
   localparam int NUM_CHAN   = 4;
   localparam int NUM_CORNER = 4;
   localparam int CORNER_W   = CHAN_W * NUM_CHAN;
   localparam int REQ_W      = 2 * POS_W;
   localparam int RSP_W      = CHAN_W * NUM_CHAN;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // fraction in units of 1/65536, the value one included
   localparam int FRAC_BITS = 16;
   localparam int QUO_W     = FRAC_BITS + 1;

   // restoring divider split over pipeline stages
   localparam int DIV_STEPS_PER_STAGE = 4;
   localparam int DIV_STAGES = (QUO_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

   // interpolation widths
   localparam int EDGE_W  = CHAN_W + FRAC_BITS;
   localparam int CROSS_W = EDGE_W + FRAC_BITS;

   // pipeline stage numbers
   localparam int STG_CLAMP   = 0;
   localparam int STG_VERT    = STG_CLAMP + DIV_STAGES + 1;
   localparam int STG_HORIZ   = STG_VERT + 1;
   localparam int STG_SUM     = STG_HORIZ + 1;
   localparam int PIPE_STAGES = STG_SUM + 1;

   // corner order in the register map and in the corner arrays
   localparam int CORNER_TL = 0;
   localparam int CORNER_TR = 1;
   localparam int CORNER_BR = 2;
   localparam int CORNER_BL = 3;

   // alpha is the last channel (lowest byte of a packed colour)
   localparam int CHAN_ALPHA = 3;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [QUO_W-1:0]  frac_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOP_LEFT     = 3'd0,
      CSR_TOP_RIGHT    = 3'd1,
      CSR_BOTTOM_RIGHT = 3'd2,
      CSR_BOTTOM_LEFT  = 3'd3,
      CSR_RECT_WIDTH   = 3'd4,
      CSR_RECT_HEIGHT  = 3'd5,
      CSR_PREMULTIPLY  = 3'd6
   } csr_index_type;

   // load enables of the three interpolation stages
   typedef struct packed {
      logic vert_adv;
      logic horiz_adv;
      logic sum_adv;
   } lerp_adv_type;

endpackage

// File: src/bgf_frac_div.sv
// pipelined restoring divider: frac = floor(pos * 65536 / denom), pos <= denom
// depends on bgf_pkg; one quotient bit per step, several steps per stage

module bgf_frac_div (
   input  logic                               clock,
   input  logic [bgf_pkg::DIV_STAGES-1:0]     stage_adv,
   input  logic [bgf_pkg::POS_W-1:0]          pos,
   input  logic [bgf_pkg::SIDE_W-1:0]         denom,
   output bgf_pkg::frac_type                  frac
);
   import bgf_pkg::*;

   logic [SIDE_W-1:0] rem_ff  [DIV_STAGES];
   logic [QUO_W-1:0]  quo_ff  [DIV_STAGES];
   logic [SIDE_W-1:0] rem_in  [DIV_STAGES];
   logic [QUO_W-1:0]  quo_in  [DIV_STAGES];
   logic [SIDE_W-1:0] rem_src [DIV_STAGES];
   logic [QUO_W-1:0]  quo_src [DIV_STAGES];
   logic              denom_nz;

   // a zero denominator means a side of one: fraction stays zero
   assign denom_nz = (denom != '0);

   // stage inputs: the item position for the first stage, the previous stage after
   always_comb begin
      rem_src[0] = SIDE_W'(pos);
      quo_src[0] = '0;
      for (int s = 1; s < DIV_STAGES; s++) begin
         rem_src[s] = rem_ff[s-1];
         quo_src[s] = quo_ff[s-1];
      end
   end

   // compare and subtract steps; the first step has no doubling (bit for one)
   always_comb begin
      logic [SIDE_W:0]   trial;
      logic [SIDE_W-1:0] rem;
      logic [QUO_W-1:0]  quo;
      logic              qbit;
      trial = '0;
      rem   = '0;
      quo   = '0;
      qbit  = 1'b0;
      for (int s = 0; s < DIV_STAGES; s++) begin
         rem = rem_src[s];
         quo = quo_src[s];
         for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
            if (s * DIV_STEPS_PER_STAGE + k < QUO_W) begin
               if (s == 0 && k == 0) begin
                  trial = {1'b0, rem};
               end else begin
                  trial = {rem, 1'b0};
               end
               qbit = denom_nz && (trial >= {1'b0, denom});
               if (qbit) begin
                  trial = trial - {1'b0, denom};
               end
               rem = trial[SIDE_W-1:0];
               quo = {quo[QUO_W-2:0], qbit};
            end
         end
         rem_in[s] = rem;
         quo_in[s] = quo;
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (stage_adv[s]) begin
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
         end
      end
   end

   assign frac = quo_ff[DIV_STAGES-1];

endmodule

// File: src/bgf_chan_lerp.sv
// one colour channel of the bilinear blend: vertical edges, then across
// depends on bgf_pkg; three register stages, load enables from the top level

module bgf_chan_lerp (
   input  logic                  clock,
   input  bgf_pkg::lerp_adv_type adv,
   input  bgf_pkg::chan_type     top_left,
   input  bgf_pkg::chan_type     top_right,
   input  bgf_pkg::chan_type     bottom_right,
   input  bgf_pkg::chan_type     bottom_left,
   input  bgf_pkg::frac_type     frac_x,
   input  bgf_pkg::frac_type     frac_y,
   output bgf_pkg::chan_type     chan_out
);
   import bgf_pkg::*;

   logic [EDGE_W-1:0]  left_ff, left_in;
   logic [EDGE_W-1:0]  right_ff, right_in;
   frac_type           fx_ff;
   logic [EDGE_W-1:0]  base_ff;
   logic [CROSS_W-1:0] cross_ff, cross_in;
   chan_type           chan_ff, chan_in;

   logic signed [CHAN_W:0]             dl, dr;
   logic signed [CHAN_W+QUO_W+1:0]     lprod, rprod;
   logic signed [EDGE_W:0]             dc;
   logic signed [EDGE_W+QUO_W+1:0]     cprod;
   logic [CROSS_W-1:0]                 sum;

   // edges: c0 * 2^16 + (c1 - c0) * fy, exact and within 24 bits
   always_comb begin
      dl       = $signed({1'b0, bottom_left}) - $signed({1'b0, top_left});
      dr       = $signed({1'b0, bottom_right}) - $signed({1'b0, top_right});
      lprod    = dl * $signed({1'b0, frac_y});
      rprod    = dr * $signed({1'b0, frac_y});
      left_in  = {top_left, {FRAC_BITS{1'b0}}} + lprod[EDGE_W-1:0];
      right_in = {top_right, {FRAC_BITS{1'b0}}} + rprod[EDGE_W-1:0];
   end

   // across: (right - left) * fx, the base is added in the next stage
   always_comb begin
      dc       = $signed({1'b0, right_ff}) - $signed({1'b0, left_ff});
      cprod    = dc * $signed({1'b0, fx_ff});
      cross_in = cprod[CROSS_W-1:0];
   end

   // final sum, keep the top byte
   always_comb begin
      sum     = {base_ff, {FRAC_BITS{1'b0}}} + cross_ff;
      chan_in = sum[CROSS_W-1 -: CHAN_W];
   end

   always_ff @(posedge clock) begin
      if (adv.vert_adv) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         fx_ff    <= frac_x;
      end
      if (adv.horiz_adv) begin
         base_ff  <= left_ff;
         cross_ff <= cross_in;
      end
      if (adv.sum_adv) begin
         chan_ff  <= chan_in;
      end
   end

   assign chan_out = chan_ff;

endmodule

// File: src/bilinear_gradient_fill_unit.sv
// bilinear gradient fill unit: pixel coordinate in, RGBA8 colour out
// pipeline: nine stages (clamp, 5 divider stages, vertical blend, horizontal product,
//   final sum); one word per cycle while rsp_tready does not hold the output
// the divider stages come from the 17-step fraction divider, at most 4 quotient bits a stage
// reset: synchronous, clears the stage valid bits and the settings registers to their defaults
// depends on bgf_pkg, bgf_frac_div, bgf_chan_lerp

module bilinear_gradient_fill_unit (
   input  logic                             clock,
   input  logic                             reset,
   // request words
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bgf_pkg::REQ_W-1:0]        req_tdata,   // pixel_x, pixel_y
   // result words
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bgf_pkg::RSP_W-1:0]        rsp_tdata,   // red_out, green_out, blue_out, alpha_out
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bgf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bgf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bgf_pkg::*;

   logic [CORNER_W-1:0] corner_ff [NUM_CORNER];
   logic [SIDE_W-1:0]   denom_x_ff;
   logic [SIDE_W-1:0]   denom_y_ff;
   logic                premult_ff;

   chan_type            pm_ff [NUM_CORNER][NUM_CHAN];
   chan_type            pm_in [NUM_CORNER][NUM_CHAN];

   logic [PIPE_STAGES-1:0] valid_ff, valid_in;
   logic [PIPE_STAGES-1:0] stage_ready;
   logic [PIPE_STAGES-1:0] valid_chain;

   logic [POS_W-1:0]    pos_x_ff, pos_x_in;
   logic [POS_W-1:0]    pos_y_ff, pos_y_in;
   frac_type            frac_x, frac_y;
   lerp_adv_type        lerp_adv;
   chan_type            chan_out [NUM_CHAN];

   // side to divisor: side minus one after the zero and upper clips
   function automatic logic [SIDE_W-1:0] side_denom(input logic [SIDE_W-1:0] side);
      logic [SIDE_W-1:0] d;
      if (32'(side) > MAX_SIDE) begin
         d = SIDE_W'(MAX_SIDE - 1);
      end else if (side == '0) begin
         d = '0;
      end else begin
         d = side - 1'b1;
      end
      return d;
   endfunction

   // floor(p / 255) for p up to 255 * 255
   function automatic chan_type div255(input logic [2*CHAN_W-1:0] p);
      logic [2*CHAN_W:0] t;
      t = (2*CHAN_W+1)'(p) + (2*CHAN_W+1)'(p[2*CHAN_W-1:CHAN_W]) + 1'b1;
      return t[2*CHAN_W-1:CHAN_W];
   endfunction

   // register writes, always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CORNER; c++) begin
            corner_ff[c] <= '0;
         end
         denom_x_ff <= '0;
         denom_y_ff <= '0;
         premult_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TOP_LEFT:     corner_ff[CORNER_TL] <= csr_wdata[CORNER_W-1:0];
            CSR_TOP_RIGHT:    corner_ff[CORNER_TR] <= csr_wdata[CORNER_W-1:0];
            CSR_BOTTOM_RIGHT: corner_ff[CORNER_BR] <= csr_wdata[CORNER_W-1:0];
            CSR_BOTTOM_LEFT:  corner_ff[CORNER_BL] <= csr_wdata[CORNER_W-1:0];
            CSR_RECT_WIDTH:   denom_x_ff <= side_denom(csr_wdata[SIDE_W-1:0]);
            CSR_RECT_HEIGHT:  denom_y_ff <= side_denom(csr_wdata[SIDE_W-1:0]);
            CSR_PREMULTIPLY:  premult_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // corner colours, premultiplied by their alpha when enabled
   always_comb begin
      chan_type            v;
      chan_type            a;
      logic [2*CHAN_W-1:0] p;
      for (int c = 0; c < NUM_CORNER; c++) begin
         a = corner_ff[c][CHAN_W-1:0];
         for (int k = 0; k < NUM_CHAN; k++) begin
            v = corner_ff[c][CORNER_W-1-CHAN_W*k -: CHAN_W];
            p = v * a;
            if (premult_ff && k != CHAN_ALPHA) begin
               pm_in[c][k] = div255(p);
            end else begin
               pm_in[c][k] = v;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pm_ff <= pm_in;
   end

   // stage handshake: a stage loads when it is empty or its word moves on
   always_comb begin
      stage_ready[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || rsp_tready;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
      valid_chain = {valid_ff[PIPE_STAGES-2:0], req_tvalid};
      valid_in    = (stage_ready & valid_chain) | (~stage_ready & valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_ready[STG_CLAMP];
   assign rsp_tvalid = valid_ff[PIPE_STAGES-1];

   // clamp the coordinate to the last column and row
   always_comb begin
      pos_x_in = req_tdata[POS_W-1:0];
      pos_y_in = req_tdata[2*POS_W-1:POS_W];
      if (SIDE_W'(pos_x_in) > denom_x_ff) begin
         pos_x_in = denom_x_ff[POS_W-1:0];
      end
      if (SIDE_W'(pos_y_in) > denom_y_ff) begin
         pos_y_in = denom_y_ff[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[STG_CLAMP]) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   // fractions across and down
   bgf_frac_div u_div_x (
      .clock     (clock),
      .stage_adv (stage_ready[STG_CLAMP+DIV_STAGES:STG_CLAMP+1]),
      .pos       (pos_x_ff),
      .denom     (denom_x_ff),
      .frac      (frac_x)
   );

   bgf_frac_div u_div_y (
      .clock     (clock),
      .stage_adv (stage_ready[STG_CLAMP+DIV_STAGES:STG_CLAMP+1]),
      .pos       (pos_y_ff),
      .denom     (denom_y_ff),
      .frac      (frac_y)
   );

   // one interpolation lane per channel
   assign lerp_adv.vert_adv  = stage_ready[STG_VERT];
   assign lerp_adv.horiz_adv = stage_ready[STG_HORIZ];
   assign lerp_adv.sum_adv   = stage_ready[STG_SUM];

   for (genvar k = 0; k < NUM_CHAN; k++) begin : g_lane
      bgf_chan_lerp u_lerp (
         .clock        (clock),
         .adv          (lerp_adv),
         .top_left     (pm_ff[CORNER_TL][k]),
         .top_right    (pm_ff[CORNER_TR][k]),
         .bottom_right (pm_ff[CORNER_BR][k]),
         .bottom_left  (pm_ff[CORNER_BL][k]),
         .frac_x       (frac_x),
         .frac_y       (frac_y),
         .chan_out     (chan_out[k])
      );
      assign rsp_tdata[k*CHAN_W +: CHAN_W] = chan_out[k];
   end

`ifndef SYNTHESIS
   // an accepted word always lands in the first stage
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[STG_CLAMP])
      else $error("accepted request word did not enter the pipeline");

   // an empty pipeline never refuses a request
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (valid_ff == '0) |-> req_tready)
      else $error("request refused with an empty pipeline");

   // a taken result with nothing behind it leaves the output empty
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !valid_ff[PIPE_STAGES-2]) |=> !rsp_tvalid)
      else $error("result word repeated or invented");
`endif

endmodule

// File: bench/tb_top.sv
// self-checking bench for bilinear_gradient_fill_unit: directed and random pixel words,
// several register settings, random idling on both streams, per-channel colour checks
// depends on bgf_pkg and bilinear_gradient_fill_unit
`timescale 1ns / 1ps

module tb_top;
   import bgf_pkg::*;

   localparam int CHAN_FULL = 255;
   localparam logic [63:0] FRAC_ONE = 64'd1 << FRAC_BITS;
   localparam int SETTLE_CYCLES = PIPE_STAGES + 3;
   localparam int RANDOM_PHASES = 12;
   localparam int PIXELS_PER_PHASE = 118;
   localparam int REPORT_CAP = 40;
   // register index outside the map, writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct {
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      bit               drain_first;
   } fill_request_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;      // pixel_x, pixel_y
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;           // red_out, green_out, blue_out, alpha_out
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the block's registers, updated on accepted register words
   logic [CORNER_W-1:0]   corner_colour [NUM_CORNER] = '{default: '0};
   logic [SIDE_W-1:0]     fill_width = 13'd1;
   logic [SIDE_W-1:0]     fill_height = 13'd1;
   logic                  premul_on = 1'b0;

   fill_request_type      fill_requests [$];
   logic [RSP_W-1:0]      predicted_pixels [$];
   int                    req_issued = 0;
   int                    req_accepts = 0;
   int                    fault_count = 0;
   int                    req_gap = 0;
   int                    rsp_stall = 0;
   int                    req_idle_pct = 20;
   int                    rsp_stall_pct = 20;
   bit                    quiet_tail = 1'b0;
   string                 chan_name [NUM_CHAN] = '{"red", "green", "blue", "alpha"};

   bilinear_gradient_fill_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // colour prediction

   // zero counts as one, oversized sides are clipped
   function automatic logic [SIDE_W-1:0] clip_side(input logic [SIDE_W-1:0] side);
      if (side == 0) return SIDE_W'(1);
      if (side > MAX_SIDE) return SIDE_W'(MAX_SIDE);
      return side;
   endfunction

   // position along a side as a fraction in 1/65536 units, one included
   function automatic logic [QUO_W-1:0] edge_fraction(input logic [POS_W-1:0] pos,
                                                      input logic [SIDE_W-1:0] side);
      logic [SIDE_W-1:0] span;
      logic [63:0]       p;
      span = clip_side(side);
      if (span <= 1) return '0;
      p = 64'(pos);
      if (p > 64'(span - 1)) p = 64'(span - 1);
      return QUO_W'((p << FRAC_BITS) / 64'(span - 1));
   endfunction

   // channel k of a packed corner colour, red in the top byte
   function automatic logic [63:0] corner_channel(input logic [CORNER_W-1:0] colour,
                                                  input int k);
      logic [63:0] v;
      logic [63:0] a;
      v = 64'(colour[CHAN_W*(NUM_CHAN-1-k) +: CHAN_W]);
      a = 64'(colour[CHAN_W-1:0]);
      if (premul_on && k != CHAN_ALPHA) v = (v * a) / CHAN_FULL;
      return v;
   endfunction

   function automatic logic [RSP_W-1:0] blend_pixel(input logic [POS_W-1:0] px,
                                                    input logic [POS_W-1:0] py);
      logic [63:0]      fx;
      logic [63:0]      fy;
      logic [63:0]      left_edge;
      logic [63:0]      right_edge;
      logic [63:0]      mix;
      logic [RSP_W-1:0] colour;
      colour = '0;
      fx = 64'(edge_fraction(px, fill_width));
      fy = 64'(edge_fraction(py, fill_height));
      for (int k = 0; k < NUM_CHAN; k++) begin
         left_edge  = corner_channel(corner_colour[CORNER_TL], k) * (FRAC_ONE - fy)
                    + corner_channel(corner_colour[CORNER_BL], k) * fy;
         right_edge = corner_channel(corner_colour[CORNER_TR], k) * (FRAC_ONE - fy)
                    + corner_channel(corner_colour[CORNER_BR], k) * fy;
         mix = (left_edge * (FRAC_ONE - fx) + right_edge * fx) >> (2 * FRAC_BITS);
         colour[CHAN_W*k +: CHAN_W] = mix[CHAN_W-1:0];
      end
      return colour;
   endfunction

   task automatic apply_reg_write(input logic [CSR_IDX_W-1:0] idx,
                                  input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_TOP_LEFT:     corner_colour[CORNER_TL] = data;
         CSR_TOP_RIGHT:    corner_colour[CORNER_TR] = data;
         CSR_BOTTOM_RIGHT: corner_colour[CORNER_BR] = data;
         CSR_BOTTOM_LEFT:  corner_colour[CORNER_BL] = data;
         CSR_RECT_WIDTH:   fill_width = data[SIDE_W-1:0];
         CSR_RECT_HEIGHT:  fill_height = data[SIDE_W-1:0];
         CSR_PREMULTIPLY:  premul_on = data[0];
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // request driver: one pixel word per handshake, random gaps between words
   always @(negedge clock) begin : req_drive
      fill_request_type head;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_accepts == req_issued) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (fill_requests.size() != 0 &&
                      !(fill_requests[0].drain_first &&
                        (predicted_pixels.size() != 0 || req_accepts != req_issued))) begin
            head = fill_requests.pop_front();
            req_tdata  <= {head.row, head.col};
            req_tvalid <= 1'b1;
            req_issued++;
            if (!quiet_tail && $urandom_range(0, 99) < req_idle_pct)
               req_gap = $urandom_range(1, 18);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result back-pressure in bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_stall = $urandom_range(1, 18) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: track register words, predict on accepted pixels, check results
   always @(posedge clock) begin : observe
      logic [RSP_W-1:0] want;
      if (!reset) begin
         if (csr_valid && csr_ready) apply_reg_write(csr_index, csr_wdata);
         if (req_tvalid && req_tready) begin
            predicted_pixels.push_back(blend_pixel(req_tdata[POS_W-1:0],
                                                   req_tdata[REQ_W-1:POS_W]));
            req_accepts++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_pixels.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_CAP)
                  $display("%0t: result word %h with none expected, expected none",
                           $time, rsp_tdata);
            end else begin
               want = predicted_pixels.pop_front();
               for (int k = 0; k < NUM_CHAN; k++) begin
                  if (rsp_tdata[CHAN_W*k +: CHAN_W] !== want[CHAN_W*k +: CHAN_W]) begin
                     fault_count++;
                     if (fault_count <= REPORT_CAP)
                        $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                                 chan_name[k], want[CHAN_W*k +: CHAN_W],
                                 rsp_tdata[CHAN_W*k +: CHAN_W]);
                  end
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus

   task automatic queue_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                              input bit drain_first = 1'b0);
      fill_request_type r;
      r.col = x;
      r.row = y;
      r.drain_first = drain_first;
      fill_requests.push_back(r);
   endtask

   // all pixels sent and answered, then let the pipeline run dry
   task automatic settle;
      while (fill_requests.size() != 0 || req_accepts != req_issued ||
             predicted_pixels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes need no lowering
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic csr_idle;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_fill(input logic [CORNER_W-1:0] tl, input logic [CORNER_W-1:0] tr,
                           input logic [CORNER_W-1:0] br, input logic [CORNER_W-1:0] bl,
                           input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                           input bit pm);
      // unused upper data bits carry junk, the block must ignore it
      write_reg(CSR_TOP_LEFT, tl);
      write_reg(CSR_TOP_RIGHT, tr);
      write_reg(CSR_BOTTOM_RIGHT, br);
      write_reg(CSR_BOTTOM_LEFT, bl);
      write_reg(CSR_RECT_WIDTH, ($urandom & ~32'h1FFF) | CSR_DATA_W'(w));
      write_reg(CSR_RECT_HEIGHT, ($urandom & ~32'h1FFF) | CSR_DATA_W'(h));
      write_reg(CSR_PREMULTIPLY, ($urandom & ~32'h1) | CSR_DATA_W'(pm));
      csr_idle();
   endtask

   function automatic logic [SIDE_W-1:0] random_side();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return SIDE_W'(1);
         2:       return SIDE_W'(2);
         3:       return SIDE_W'(MAX_SIDE);
         4:       return SIDE_W'($urandom_range(MAX_SIDE + 1, 8191));
         5, 6:    return SIDE_W'($urandom_range(2, 32));
         default: return SIDE_W'($urandom_range(1, MAX_SIDE));
      endcase
   endfunction

   function automatic logic [CORNER_W-1:0] random_corner();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return {24'($urandom), 8'hFF};
         3:       return {24'($urandom), 8'h00};
         default: return CORNER_W'($urandom);
      endcase
   endfunction

   // mostly inside the rectangle, some extremes and some past the edge
   function automatic logic [POS_W-1:0] random_pos(input logic [SIDE_W-1:0] side);
      case ($urandom_range(0, 9))
         0:       return '1;
         1:       return '0;
         2, 3:    return POS_W'($urandom);
         default: return POS_W'($urandom_range(0, clip_side(side) - 1));
      endcase
   endfunction

   function automatic int random_idle_pct();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 5;
         2:       return 20;
         default: return 50;
      endcase
   endfunction

   initial begin
      logic [SIDE_W-1:0] w;
      logic [SIDE_W-1:0] h;
      int                drain_at;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: black corners, one-pixel rectangle
      queue_pixel('0, '0);
      queue_pixel('1, '1);

      // full-size rectangle, straight colours, all four corners and inside
      settle();
      set_fill(32'hFF00_00FF, 32'h00FF_0080, 32'h0000_FF00, 32'hFFFF_FFFF,
               SIDE_W'(MAX_SIDE), SIDE_W'(MAX_SIDE), 1'b0);
      queue_pixel(12'd0, 12'd0);
      queue_pixel(12'd4095, 12'd0);
      queue_pixel(12'd4095, 12'd4095);
      queue_pixel(12'd0, 12'd4095);
      queue_pixel(12'd2047, 12'd2048);
      queue_pixel(12'd1, 12'd4094);

      // same corners premultiplied, transparent corner goes black
      settle();
      set_fill(32'hFF00_00FF, 32'h00FF_0080, 32'h0000_FF00, 32'hFFFF_FFFF,
               SIDE_W'(MAX_SIDE), SIDE_W'(MAX_SIDE), 1'b1);
      queue_pixel(12'd0, 12'd0);
      queue_pixel(12'd4095, 12'd0);
      queue_pixel(12'd4095, 12'd4095);
      queue_pixel(12'd0, 12'd4095);
      queue_pixel(12'd3000, 12'd1000);

      // side of one across, side of zero down
      settle();
      set_fill(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F1E_2D3C, 32'hF0E1_D2C3,
               SIDE_W'(1), '0, 1'b0);
      queue_pixel(12'd4095, 12'd4095);
      queue_pixel(12'd0, 12'd0);
      queue_pixel(12'd77, 12'd3000);

      // oversized sides clip to the largest rectangle
      settle();
      set_fill(32'h00FF_FF00, 32'hFF00_00FF, 32'h8080_8080, 32'h7F7F_7F7F,
               13'd8191, SIDE_W'(MAX_SIDE + 1), 1'b1);
      queue_pixel(12'd4095, 12'd4095);
      queue_pixel(12'd1024, 12'd2049);

      // coordinates past the rectangle clamp to the last column and row;
      // a write to an unmapped index must change nothing
      settle();
      set_fill(32'hFFFF_0000, 32'h0000_FFFF, 32'hFF00_FF00, 32'h00FF_00FF,
               13'd100, 13'd3, 1'b0);
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      csr_idle();
      queue_pixel(12'd99, 12'd2);
      queue_pixel(12'd4095, 12'd4095);
      queue_pixel(12'd150, 12'd1);

      // saturated corners, smallest rectangle with a far edge
      settle();
      set_fill('1, '1, '1, '1, 13'd2, 13'd2, 1'b1);
      queue_pixel(12'd0, 12'd0);
      queue_pixel(12'd1, 12'd1);
      queue_pixel(12'd4095, 12'd0);

      // random settings and pixels, the last phase without idling
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         if (ph == RANDOM_PHASES - 1) quiet_tail = 1'b1;
         req_idle_pct  = random_idle_pct();
         rsp_stall_pct = random_idle_pct();
         w = random_side();
         h = random_side();
         set_fill(random_corner(), random_corner(), random_corner(), random_corner(),
                  w, h, 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 1) == 1) begin
            write_reg(CSR_UNUSED, $urandom);
            csr_idle();
         end
         drain_at = $urandom_range(10, PIXELS_PER_PHASE - 10);
         for (int n = 0; n < PIXELS_PER_PHASE; n++)
            queue_pixel(random_pos(w), random_pos(h), n == drain_at);
      end

      settle();
      repeat (2 * PIPE_STAGES) @(posedge clock);
      if (fault_count == 0 && predicted_pixels.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
